@@ hdl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants for the segment-segment intersection block:
// beat payloads of the input and result channels and the fixed field widths.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // Width of every coordinate field on the channels
  localparam int FIELD_W = 32;
  // Fraction bits of the segment parameter t, and its width (t may equal one)
  localparam int T_BITS  = 16;
  localparam int T_W     = T_BITS + 1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_start_x;
    logic signed [FIELD_W-1:0] first_start_y;
    logic signed [FIELD_W-1:0] first_end_x;
    logic signed [FIELD_W-1:0] first_end_y;
    logic signed [FIELD_W-1:0] second_start_x;
    logic signed [FIELD_W-1:0] second_start_y;
    logic signed [FIELD_W-1:0] second_end_x;
    logic signed [FIELD_W-1:0] second_end_y;
  } ssi_in_t;

  typedef struct packed {
    logic                      hit;
    logic                      degenerate;
    logic        [T_W-1:0]     along_first;
    logic signed [FIELD_W-1:0] cross_x;
    logic signed [FIELD_W-1:0] cross_y;
  } ssi_out_t;

endpackage

@@ hdl/ssi_in_if.sv @@
// ----------------------------------------------------------------------------
// ssi_in_if
// Valid/ready channel carrying one pair of segments per beat.
// ----------------------------------------------------------------------------
interface ssi_in_if import ssi_pkg::*; ();

  logic    valid;
  logic    ready;
  ssi_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/ssi_out_if.sv @@
// ----------------------------------------------------------------------------
// ssi_out_if
// Valid/ready channel carrying one intersection result per beat.
// ----------------------------------------------------------------------------
interface ssi_out_if import ssi_pkg::*; ();

  logic     valid;
  logic     ready;
  ssi_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/segment_segment_intersect.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect
// Streaming 2D segment intersection test in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per segment pair, first = A->B, second = C->D. Only the
//            low COORD_WIDTH bits of each coordinate are used, sign-extended.
//   out_ch : one beat per input beat, in order: hit, degenerate, t along the
//            first segment (unsigned Q1.16, 65536 is one) and the crossing
//            point. A miss gives an all-zero beat; collinear segments give
//            hit and degenerate with t = 0 and the point equal to A.
//   Depth  : 24 register stages.
//   Throughput: one beat per cycle when not stalled. The depth is set by the
//            restoring divider for t, one quotient bit per stage (17 stages),
//            behind five stages of area arithmetic and two of interpolation.
//   Reset  : rst_n (synchronous, active low) empties the pipeline; data
//            registers are not cleared.
//   Stall  : every stage holds its beat while the stage after it is full and
//            held; bubbles are squeezed out, so in_ch.ready stays high while
//            any stage is empty, even with a result waiting at the output.
// ----------------------------------------------------------------------------
module segment_segment_intersect import ssi_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ssi_in_if.sink    in_ch,
  ssi_out_if.source out_ch
);

  // Widths: coordinate difference, product, area, denominator, fourth area,
  // and the interpolation product t * (B - A)
  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int PW  = 2 * DW;
  localparam int AW  = PW + 1;
  localparam int NW  = AW + 1;
  localparam int A4W = NW + 1;
  localparam int LW  = DW + T_W + 1;

  // Stage map
  localparam int S_DIFF = 0;  // coordinate differences
  localparam int S_PROD = 1;  // six products
  localparam int S_AREA = 2;  // three areas
  localparam int S_DEN  = 3;  // denominator a1 - a2, first side test
  localparam int S_A4   = 4;  // fourth area, hit, magnitudes
  localparam int NDIV   = T_W;
  localparam int S_DIV0 = S_A4 + 1;
  localparam int S_MUL  = S_DIV0 + NDIV;
  localparam int S_OUT  = S_MUL + 1;
  localparam int NST    = S_OUT + 1;

  // --------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or the next one advances
  // --------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] adv;

  assign adv[NST-1] = !v_r[NST-1] || out_ch.ready;

  for (genvar i = 0; i < NST - 1; i++) begin : g_adv
    assign adv[i] = !v_r[i] || adv[i+1];
  end

  assign in_ch.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: sign-extend the coordinates and take differences
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c, dx_c, dy_c;

  assign ax_c = DW'($signed(in_ch.data.first_start_x[CW-1:0]));
  assign ay_c = DW'($signed(in_ch.data.first_start_y[CW-1:0]));
  assign bx_c = DW'($signed(in_ch.data.first_end_x[CW-1:0]));
  assign by_c = DW'($signed(in_ch.data.first_end_y[CW-1:0]));
  assign cx_c = DW'($signed(in_ch.data.second_start_x[CW-1:0]));
  assign cy_c = DW'($signed(in_ch.data.second_start_y[CW-1:0]));
  assign dx_c = DW'($signed(in_ch.data.second_end_x[CW-1:0]));
  assign dy_c = DW'($signed(in_ch.data.second_end_y[CW-1:0]));

  // a1 = area(A,B,D), a2 = area(A,B,C), a3 = area(C,D,A)
  logic signed [DW-1:0] adx_r, bdy_r, ady_r, bdx_r;
  logic signed [DW-1:0] acx_r, bcy_r, acy_r, bcx_r;
  logic signed [DW-1:0] cax_r, day_r, cay_r, dax_r;

  // Point A and the direction B - A ride alongside
  logic signed [CW-1:0] ax_r  [S_DIFF:S_MUL];
  logic signed [CW-1:0] ay_r  [S_DIFF:S_MUL];
  logic signed [DW-1:0] bax_r [S_DIFF:S_MUL-1];
  logic signed [DW-1:0] bay_r [S_DIFF:S_MUL-1];

  always_ff @(posedge clk) begin
    if (adv[S_DIFF]) begin
      adx_r <= ax_c - dx_c;
      bdy_r <= by_c - dy_c;
      ady_r <= ay_c - dy_c;
      bdx_r <= bx_c - dx_c;
      acx_r <= ax_c - cx_c;
      bcy_r <= by_c - cy_c;
      acy_r <= ay_c - cy_c;
      bcx_r <= bx_c - cx_c;
      cax_r <= cx_c - ax_c;
      day_r <= dy_c - ay_c;
      cay_r <= cy_c - ay_c;
      dax_r <= dx_c - ax_c;
      ax_r[S_DIFF]  <= ax_c[CW-1:0];
      ay_r[S_DIFF]  <= ay_c[CW-1:0];
      bax_r[S_DIFF] <= bx_c - ax_c;
      bay_r[S_DIFF] <= by_c - ay_c;
    end
  end

  for (genvar i = S_DIFF + 1; i <= S_MUL; i++) begin : g_side_a
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        ax_r[i] <= ax_r[i-1];
        ay_r[i] <= ay_r[i-1];
      end
    end
  end

  for (genvar i = S_DIFF + 1; i < S_MUL; i++) begin : g_side_d
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        bax_r[i] <= bax_r[i-1];
        bay_r[i] <= bay_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] p1a_r, p1b_r, p2a_r, p2b_r, p3a_r, p3b_r;

  always_ff @(posedge clk) begin
    if (adv[S_PROD]) begin
      p1a_r <= PW'(adx_r) * PW'(bdy_r);
      p1b_r <= PW'(ady_r) * PW'(bdx_r);
      p2a_r <= PW'(acx_r) * PW'(bcy_r);
      p2b_r <= PW'(acy_r) * PW'(bcx_r);
      p3a_r <= PW'(cax_r) * PW'(day_r);
      p3b_r <= PW'(cay_r) * PW'(dax_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: doubled signed areas
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] a1_r, a2_r, a3_r;

  always_ff @(posedge clk) begin
    if (adv[S_AREA]) begin
      a1_r <= AW'(p1a_r) - AW'(p1b_r);
      a2_r <= AW'(p2a_r) - AW'(p2b_r);
      a3_r <= AW'(p3a_r) - AW'(p3b_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: denominator a3 - a4 = a1 - a2; C and D strictly on one side of AB
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] den_r;
  logic signed [AW-1:0] a3d_r;
  logic                 side12_r;

  always_ff @(posedge clk) begin
    if (adv[S_DEN]) begin
      den_r    <= NW'(a1_r) - NW'(a2_r);
      a3d_r    <= a3_r;
      side12_r <= (a1_r != '0) && (a2_r != '0) && (a1_r[AW-1] == a2_r[AW-1]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: fourth area, hit decision and magnitudes for the divider
  // --------------------------------------------------------------------------
  logic signed [A4W-1:0] a4_c;
  logic signed [NW-1:0]  a3e_c;
  logic                  side34_c;

  assign a4_c     = A4W'(a3d_r) - A4W'(den_r);
  assign a3e_c    = NW'(a3d_r);
  assign side34_c = (a3d_r != '0) && (a4_c != '0) && (a3d_r[AW-1] == a4_c[A4W-1]);

  logic          hit_r   [S_A4:S_OUT];
  logic          degen_r [S_A4:S_OUT];
  logic [NW-1:0] num_r;
  logic [NW-1:0] dmag_r;

  always_ff @(posedge clk) begin
    if (adv[S_A4]) begin
      hit_r[S_A4]   <= !side12_r && !side34_c;
      degen_r[S_A4] <= !side12_r && !side34_c && (den_r == '0);
      num_r         <= a3e_c[NW-1] ? NW'(-a3e_c) : NW'(a3e_c);
      dmag_r        <= den_r[NW-1] ? NW'(-den_r) : NW'(den_r);
    end
  end

  for (genvar i = S_A4 + 1; i <= S_OUT; i++) begin : g_side_h
    always_ff @(posedge clk) begin
      if (adv[i]) begin
        hit_r[i]   <= hit_r[i-1];
        degen_r[i] <= degen_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: t = floor(|a3| * 2^16 / |a3 - a4|), restoring, one bit per stage.
  // The first step has no shift and yields the integer bit of t.
  // --------------------------------------------------------------------------
  logic [NW-1:0]  rem_r [0:NDIV-2];
  logic [NW-1:0]  dd_r  [0:NDIV-2];
  logic [T_W-1:0] q_r   [0:NDIV-1];

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [NW:0]    sh_c;
    logic [NW+1:0]  diff_c;
    logic [NW-1:0]  den_c;
    logic [T_W-1:0] qin_c;
    logic           ge_c;

    if (k == 0) begin : g_first
      assign sh_c  = {1'b0, num_r};
      assign den_c = dmag_r;
      assign qin_c = '0;
    end else begin : g_next
      assign sh_c  = {rem_r[k-1], 1'b0};
      assign den_c = dd_r[k-1];
      assign qin_c = q_r[k-1];
    end

    assign diff_c = (NW + 2)'(sh_c) - (NW + 2)'(den_c);
    assign ge_c   = !diff_c[NW+1];

    always_ff @(posedge clk) begin
      if (adv[S_DIV0+k]) begin
        q_r[k] <= {qin_c[T_W-2:0], ge_c};
      end
    end

    if (k < NDIV - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv[S_DIV0+k]) begin
          rem_r[k] <= ge_c ? diff_c[NW-1:0] : sh_c[NW-1:0];
          dd_r[k]  <= den_c;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Interpolation: drop t on a miss or collinear pair, multiply by B - A
  // --------------------------------------------------------------------------
  logic [T_W-1:0]       t_c;
  logic [T_W-1:0]       t_mul_r;
  logic signed [LW-1:0] ox_r, oy_r;

  assign t_c = (hit_r[S_MUL-1] && !degen_r[S_MUL-1]) ? q_r[NDIV-1] : '0;

  always_ff @(posedge clk) begin
    if (adv[S_MUL]) begin
      t_mul_r <= t_c;
      ox_r    <= LW'($signed({1'b0, t_c})) * LW'(bax_r[S_MUL-1]);
      oy_r    <= LW'($signed({1'b0, t_c})) * LW'(bay_r[S_MUL-1]);
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: A + floor(t * (B - A) / 2^16), zero on a miss
  // --------------------------------------------------------------------------
  logic signed [LW-1:0]      sx_c, sy_c;
  logic [T_W-1:0]            t_out_r;
  logic signed [FIELD_W-1:0] cross_x_r, cross_y_r;

  assign sx_c = LW'(ax_r[S_MUL]) + (ox_r >>> T_BITS);
  assign sy_c = LW'(ay_r[S_MUL]) + (oy_r >>> T_BITS);

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      t_out_r   <= t_mul_r;
      cross_x_r <= hit_r[S_MUL] ? FIELD_W'($signed(sx_c[CW-1:0])) : '0;
      cross_y_r <= hit_r[S_MUL] ? FIELD_W'($signed(sy_c[CW-1:0])) : '0;
    end
  end

  assign out_ch.valid            = v_r[NST-1];
  assign out_ch.data.hit         = hit_r[S_OUT];
  assign out_ch.data.degenerate  = degen_r[S_OUT];
  assign out_ch.data.along_first = t_out_r;
  assign out_ch.data.cross_x     = cross_x_r;
  assign out_ch.data.cross_y     = cross_y_r;

endmodule

@@ tb/sv/ssi_crossing_checker.sv @@
// ----------------------------------------------------------------------------
// ssi_crossing_checker
// Watches both channels of the segment intersection block, predicts the
// result of every accepted pair and compares each result beat in order.
// ----------------------------------------------------------------------------
module ssi_crossing_checker import ssi_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  ssi_in_if    in_mon,
  ssi_out_if   out_mon,
  output int   fail_count,
  output int   pending_count
);

  localparam int MAX_REPORTS = 10;

  ssi_out_t expected_crossings[$];
  int       mismatches = 0;

  // Append one predicted beat at the tail of the queue.
  function automatic void stash_expected(ssi_out_t e);
    expected_crossings.insert(expected_crossings.size(), e);
  endfunction

  // Sign-extend the low COORD_WIDTH bits of a coordinate.
  function automatic logic signed [63:0] widen(logic [FIELD_W-1:0] v);
    logic signed [63:0] s;
    s = {32'b0, v} << (64 - COORD_WIDTH);
    return s >>> (64 - COORD_WIDTH);
  endfunction

  // Doubled signed area of triangle P,Q,R, exact.
  function automatic logic signed [127:0] doubled_area(
    logic signed [63:0] px, logic signed [63:0] py,
    logic signed [63:0] qx, logic signed [63:0] qy,
    logic signed [63:0] rx, logic signed [63:0] ry
  );
    logic signed [127:0] ux, uy, vx, vy;
    ux = px - rx;
    uy = py - ry;
    vx = qx - rx;
    vy = qy - ry;
    return ux * vy - uy * vx;
  endfunction

  function automatic int area_sign(logic signed [127:0] v);
    if (v < 0) return -1;
    return (v == 0) ? 0 : 1;
  endfunction

  // a + floor(t * (b - a) / 2^T_BITS)
  function automatic logic [FIELD_W-1:0] lerp_axis(
    logic signed [63:0] a, logic signed [63:0] b, logic [31:0] t
  );
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = $signed({32'b0, t}) * (b - a);
    r = a + (p >>> T_BITS);
    return r[FIELD_W-1:0];
  endfunction

  function automatic ssi_out_t predict_crossing(ssi_in_t pair);
    logic signed [63:0]  ax, ay, bx, by, cx, cy, dx, dy;
    logic signed [127:0] a1, a2, a3, a4, den, num, rem;
    logic [31:0]         t;
    logic                degen;
    ssi_out_t            res;
    res = '0;
    ax = widen(pair.first_start_x);
    ay = widen(pair.first_start_y);
    bx = widen(pair.first_end_x);
    by = widen(pair.first_end_y);
    cx = widen(pair.second_start_x);
    cy = widen(pair.second_start_y);
    dx = widen(pair.second_end_x);
    dy = widen(pair.second_end_y);
    a1 = doubled_area(ax, ay, bx, by, dx, dy);
    a2 = doubled_area(ax, ay, bx, by, cx, cy);
    if (area_sign(a1) * area_sign(a2) > 0) return res;
    a3 = doubled_area(cx, cy, dx, dy, ax, ay);
    a4 = a3 + a2 - a1;
    if (area_sign(a3) * area_sign(a4) > 0) return res;
    den   = a3 - a4;
    t     = '0;
    degen = 1'b0;
    if (den == 0) begin
      degen = 1'b1;
    end else begin
      num = (a3 < 0) ? -a3 : a3;
      den = (den < 0) ? -den : den;
      rem = num;
      if (rem >= den) begin
        rem = rem - den;
        t   = 32'd1;
      end
      // restoring division, one quotient bit per step
      for (int i = 0; i < T_BITS; i++) begin
        rem = rem <<< 1;
        t   = t << 1;
        if (rem >= den) begin
          rem  = rem - den;
          t[0] = 1'b1;
        end
      end
    end
    res.hit         = 1'b1;
    res.degenerate  = degen;
    res.along_first = t[T_W-1:0];
    res.cross_x     = lerp_axis(ax, bx, t);
    res.cross_y     = lerp_axis(ay, by, t);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    ssi_out_t want;
    ssi_out_t got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        stash_expected(predict_crossing(in_mon.data));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_crossings.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("unexpected result beat: hit=%0d deg=%0d t=%0d x=%0d y=%0d",
                     got.hit, got.degenerate, got.along_first, got.cross_x, got.cross_y);
          end
          mismatches++;
        end else begin
          want = expected_crossings.pop_front();
          if (got.hit !== want.hit || got.degenerate !== want.degenerate ||
              got.along_first !== want.along_first || got.cross_x !== want.cross_x ||
              got.cross_y !== want.cross_y) begin
            if (mismatches < MAX_REPORTS) begin
              $display("mismatch: exp hit=%0d deg=%0d t=%0d x=%0d y=%0d",
                       want.hit, want.degenerate, want.along_first,
                       want.cross_x, want.cross_y);
              $display("          got hit=%0d deg=%0d t=%0d x=%0d y=%0d",
                       got.hit, got.degenerate, got.along_first,
                       got.cross_x, got.cross_y);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_crossings.size();
  end

endmodule

@@ tb/sv/segment_segment_intersect_tb.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect_tb
// Streams directed and random segment pairs through the intersection block,
// with bursty input and a stalling receiver; a checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module segment_segment_intersect_tb;
  import ssi_pkg::*;

  localparam int COORD_WIDTH    = 32;
  localparam int RANDOM_ITEMS   = 1300;
  // Pipeline is 24 stages deep; DRAIN_CYCLES lets it settle at the end.
  localparam int DRAIN_CYCLES   = 48;
  // Any legal quiet spell with no beat on either channel stays far below this.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int ONE   = 65536;            // 1.0 in Q16.16
  localparam int MAX_C = 32'h7FFF_FFFF;
  localparam int MIN_C = 32'h8000_0000;

  // Shapes of random pairs
  typedef enum logic [2:0] {
    GEN_NOISE, GEN_BOX, GEN_CROSS, GEN_TOUCH, GEN_COLLINEAR, GEN_CORNER
  } pair_shape_e;

  // Receiver behaviour for one stretch of cycles
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_BURSTY, RX_COMB} rx_mode_e;

  logic clk;
  logic rst_n;

  ssi_in_if  in_ch ();
  ssi_out_if out_ch ();

  int fail_count;
  int pending_count;

  // Sender burst bookkeeping
  int burst_left;

  // Receiver pattern state
  rx_mode_e rx_mode;
  int       rx_phase_left;
  int       rx_phase_cnt;
  int       rx_stall_left;

  // Watchdog
  int quiet_cycles;

  segment_segment_intersect #(.COORD_WIDTH(COORD_WIDTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ssi_crossing_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic ssi_in_t make_pair(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
    ssi_in_t p;
    p.first_start_x  = ax;
    p.first_start_y  = ay;
    p.first_end_x    = bx;
    p.first_end_y    = by;
    p.second_start_x = cx;
    p.second_start_y = cy;
    p.second_end_x   = dx;
    p.second_end_y   = dy;
    return p;
  endfunction

  // Uniform value in [-span, span]; span stays at or below 2^30.
  function automatic int spread(int unsigned span);
    return int'($urandom_range(2 * span)) - int'(span);
  endfunction

  function automatic int unsigned pick_span();
    case ($urandom_range(2))
      0:       return 32'd1 << 8;
      1:       return 32'd1 << 16;
      default: return 32'd1 << 24;
    endcase
  endfunction

  // Extremes and small values that sit on the edges of the coordinate range
  function automatic int corner_value();
    case ($urandom_range(6))
      0:       return MAX_C;
      1:       return MIN_C;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic pair_shape_e pick_shape();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return GEN_NOISE;
    if (r < 30) return GEN_BOX;
    if (r < 65) return GEN_CROSS;
    if (r < 77) return GEN_TOUCH;
    if (r < 89) return GEN_COLLINEAR;
    return GEN_CORNER;
  endfunction

  function automatic ssi_in_t random_pair();
    int unsigned s;
    int          ax, ay, bx, by, cx, cy, dx, dy;
    int          mx, my, px, py, rx, ry, f, g, k1, k2, k3;
    s = pick_span();
    case (pick_shape())
      GEN_NOISE: begin
        // full-width noise: every bit of every field toggles
        return make_pair($urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom);
      end
      GEN_BOX: begin
        return make_pair(spread(s), spread(s), spread(s), spread(s),
                         spread(s), spread(s), spread(s), spread(s));
      end
      GEN_CROSS: begin
        // both segments pass through (about) a common point, ends on either side
        mx = spread(s);
        my = spread(s);
        px = spread(s);
        py = spread(s);
        rx = spread(s);
        ry = spread(s);
        f  = $urandom_range(1, 64);
        g  = $urandom_range(1, 64);
        ax = mx + px;
        ay = my + py;
        bx = mx - ((px * f) >>> 4);
        by = my - ((py * f) >>> 4);
        cx = mx + rx;
        cy = my + ry;
        dx = mx - ((rx * g) >>> 4);
        dy = my - ((ry * g) >>> 4);
        return make_pair(ax, ay, bx, by, cx, cy, dx, dy);
      end
      GEN_TOUCH: begin
        // one end of the second segment on the first: at A, at B or midway
        ax = spread(s);
        ay = spread(s);
        bx = spread(s);
        by = spread(s);
        case ($urandom_range(2))
          0: begin
            cx = ax;
            cy = ay;
          end
          1: begin
            cx = bx;
            cy = by;
          end
          default: begin
            cx = (ax + bx) >>> 1;
            cy = (ay + by) >>> 1;
          end
        endcase
        return make_pair(ax, ay, bx, by, cx, cy, spread(s), spread(s));
      end
      GEN_COLLINEAR: begin
        // all four points on one line; a zero step gives zero-length segments
        ax = spread(32'd1 << 24);
        ay = spread(32'd1 << 24);
        px = spread(32'd1 << 16);
        py = spread(32'd1 << 16);
        k1 = int'($urandom_range(8)) - 4;
        k2 = int'($urandom_range(8)) - 4;
        k3 = int'($urandom_range(8)) - 4;
        return make_pair(ax, ay, ax + px * k1, ay + py * k1,
                         ax + px * k2, ay + py * k2, ax + px * k3, ay + py * k3);
      end
      default: begin
        return make_pair(corner_value(), corner_value(), corner_value(), corner_value(),
                         corner_value(), corner_value(), corner_value(), corner_value());
      end
    endcase
  endfunction

  // Present one beat and hold it until accepted. Bursts of random length are
  // separated by random gaps; valid stays high across beats within a burst.
  task automatic send_beat(ssi_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and hold off until every predicted result has been seen.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    burst_left   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: crossings, touches, misses, collinear and extreme cases
    // clean X crossing at t = 1/2
    send_beat(make_pair(-ONE, -ONE, ONE, ONE, -ONE, ONE, ONE, -ONE));
    // end of second segment touching the middle of the first
    send_beat(make_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE));
    // touch at the start of the first segment, t = 0
    send_beat(make_pair(0, 0, 2 * ONE, 0, 0, 0, -ONE, ONE));
    // crossing exactly at the end of the first segment, t = 1
    send_beat(make_pair(0, 0, 2 * ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE));
    // parallel, offset: miss
    send_beat(make_pair(0, 0, ONE, 0, 0, ONE, ONE, ONE));
    // second segment beyond the end of the first: miss
    send_beat(make_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE));
    // second straddles the line but not the segment: miss on the second test
    send_beat(make_pair(0, 0, ONE, 0, 2 * ONE, ONE, 3 * ONE, -ONE));
    // collinear and overlapping
    send_beat(make_pair(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0));
    // collinear but disjoint: still reported as a degenerate hit
    send_beat(make_pair(0, 0, ONE, 0, 2 * ONE, 0, 3 * ONE, 0));
    // first segment of zero length
    send_beat(make_pair(ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 3 * ONE));
    // both segments collapsed onto one point
    send_beat(make_pair(-ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE));
    // every field at the positive extreme, then the negative one
    send_beat(make_pair(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C));
    send_beat(make_pair(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C));
    // diagonals of the whole coordinate range
    send_beat(make_pair(MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C));
    send_beat(make_pair(MAX_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C));
    // all-zero and all-ones words
    send_beat(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    // t = 1/3, rounded down
    send_beat(make_pair(0, 0, 3 * ONE, 0, ONE, -ONE, ONE, 2 * ONE));
    // negative direction: offset rounded toward minus infinity
    send_beat(make_pair(0, 0, -7, -5, -7, 0, 0, -5));
    // near-parallel across the full range: huge denominator
    send_beat(make_pair(MIN_C, 0, MAX_C, 1, MIN_C, 1, MAX_C, 0));
    // mixed-sign vertical against horizontal
    send_beat(make_pair(-3 * ONE, -ONE / 2, 5 * ONE, -ONE / 2,
                        ONE / 4, -ONE, ONE / 4, MAX_C));

    // Random part; pause once half way so the pipeline runs dry
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_until_drained();
      send_beat(random_pair());
    end
    in_ch.valid <= 1'b0;

    // Let every result come out, then allow for stray beats
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: change behaviour every stretch of cycles. Free-running spells
  // give back-to-back results; the others stall at random, in long bursts or
  // on a fixed comb so that stalls land on every phase of the pipeline.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      rx_mode       <= RX_FREE;
      rx_phase_left <= 0;
      rx_phase_cnt  <= 0;
      rx_stall_left <= 0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_mode       <= rx_mode_e'($urandom_range(3));
        rx_phase_left <= $urandom_range(20, 200);
      end else begin
        rx_phase_left <= rx_phase_left - 1;
      end
      rx_phase_cnt <= rx_phase_cnt + 1;
      case (rx_mode)
        RX_FREE: begin
          out_ch.ready <= 1'b1;
        end
        RX_COIN: begin
          out_ch.ready <= 1'($urandom_range(1));
        end
        RX_BURSTY: begin
          if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            out_ch.ready  <= 1'b0;
          end else if ($urandom_range(15) == 0) begin
            rx_stall_left <= $urandom_range(1, 20);
            out_ch.ready  <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
          end
        end
        default: begin
          out_ch.ready <= (rx_phase_cnt % 3 == 0);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles with no beat on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ segment_segment_intersect.f @@
hdl/ssi_pkg.sv
hdl/ssi_in_if.sv
hdl/ssi_out_if.sv
hdl/segment_segment_intersect.sv
tb/sv/ssi_crossing_checker.sv
tb/sv/segment_segment_intersect_tb.sv
